// File: hw/rtl/rmed_pkg.sv
// Shared types and constants for the RPC metadata envelope deframer.
// Header layout offsets, magic bytes, status codes and the result record.
// No dependencies.
package rmed_pkg;

    localparam int POSITION_WIDTH = 19;
    localparam int LEN_W          = 17;
    localparam int CMP_W          = (POSITION_WIDTH > 19 ? POSITION_WIDTH : 19) + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Header layout: magic, then timeout, then four length words
    localparam logic [POSITION_WIDTH-1:0] POS_TIMEOUT   = POSITION_WIDTH'(4);
    localparam logic [POSITION_WIDTH-1:0] POS_LENGTHS   = POSITION_WIDTH'(4 + 8);
    localparam logic [POSITION_WIDTH-1:0] POS_HEADER    = POSITION_WIDTH'(4 + 8 + 4 * 4);
    localparam logic [POSITION_WIDTH-1:0] POS_HDR_LAST  = POSITION_WIDTH'(4 + 8 + 4 * 4 - 1);
    localparam logic [POSITION_WIDTH-1:0] POS_MAX       = {POSITION_WIDTH{1'b1}};

    localparam logic [LEN_W-1:0] MAX_FIELD_RESET = LEN_W'(64 * 1024);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] TAG_SERVICE     = 2'd0;
    localparam logic [1:0] TAG_METHOD      = 2'd1;
    localparam logic [1:0] TAG_KEY         = 2'd2;
    localparam logic [1:0] TAG_APPLICATION = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic             kind;
        logic [1:0]       tag;
        logic [7:0]       data;
        t_status          status;
        logic [63:0]      timeout;
        logic [LEN_W-1:0] service_len;
        logic [LEN_W-1:0] method_len;
        logic [LEN_W-1:0] key_len;
        logic [LEN_W-1:0] app_len;
        logic             last;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h52;
            2'd1:    b = 8'h4D;
            2'd2:    b = 8'h31;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/rpc_metadata_envelope_deframer_unit.sv
// RPC metadata envelope deframer: header parse, payload tagging, status result.
// Depends on rmed_pkg for layout constants, status codes and the result record.
//
// Takes one envelope byte per cycle. The 28-byte header (magic, 64-bit timeout,
// four 32-bit lengths) is parsed as it streams in; each later byte that falls
// inside the declared fields is forwarded at once with its field tag, and the
// final byte also produces a status request carrying the timeout and lengths
// (zero on error). Results are written to a four-entry output queue at the edge
// that takes the byte, so a result is visible the cycle after acceptance.
// o_in_stall rises whenever fewer than two queue entries are free; with the
// output side taking every cycle the unit sustains one byte per cycle, and a
// final byte that is also payload costs one extra queue slot.
module rpc_metadata_envelope_deframer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [rmed_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_end_of_envelope,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_result_kind,
    output logic [1:0]                 o_field_tag,
    output logic [7:0]                 o_payload_byte,
    output logic [1:0]                 o_status,
    output logic [63:0]                o_timeout_value,
    output logic [rmed_pkg::LEN_W-1:0] o_service_length,
    output logic [rmed_pkg::LEN_W-1:0] o_method_length,
    output logic [rmed_pkg::LEN_W-1:0] o_key_length,
    output logic [rmed_pkg::LEN_W-1:0] o_application_length,
    output logic                       o_last_result
);

    localparam int PW = rmed_pkg::POSITION_WIDTH;
    localparam int CW = rmed_pkg::CMP_W;
    localparam int LW = rmed_pkg::LEN_W;
    localparam int QW = rmed_pkg::QPTR_W;
    localparam int NW = rmed_pkg::QCNT_W;

    logic [LW-1:0]  r_max;
    logic [PW-1:0]  r_pos,     n_pos;
    logic           r_magic,   n_magic;
    logic [63:0]    r_timeout, n_timeout;
    logic [31:0]    r_len [4];
    logic [31:0]    n_len [4];

    rmed_pkg::t_result r_queue [rmed_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]  r_count;

    logic           accept, pop;
    logic [PW-1:0]  len_rel;
    logic [1:0]     len_idx;
    logic           len_ok;
    logic [CW-1:0]  edge1, edge2, edge3, edge4, offset, pos_ext;
    logic           pay_hit;
    logic [1:0]     pay_tag;
    rmed_pkg::t_status st;
    rmed_pkg::t_result pay_res, stat_res, first_res, head;
    logic           push_one, push_two;

    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;
    assign o_in_stall = r_count > NW'(rmed_pkg::QUEUE_DEPTH - 2);
    assign o_out_valid = r_count != '0;

    assign len_rel = r_pos - rmed_pkg::POS_LENGTHS;
    assign len_idx = len_rel[3:2];

    // Header update for the byte at the current position
    always_comb begin
        n_magic   = r_magic;
        n_timeout = r_timeout;
        n_len     = r_len;
        if (r_pos < rmed_pkg::POS_TIMEOUT) begin
            if (i_data_byte != rmed_pkg::magic_byte(r_pos[1:0])) begin
                n_magic = 1'b0;
            end
        end else if (r_pos < rmed_pkg::POS_LENGTHS) begin
            n_timeout = {r_timeout[55:0], i_data_byte};
        end else if (r_pos < rmed_pkg::POS_HEADER) begin
            n_len[len_idx] = {r_len[len_idx][23:0], i_data_byte};
        end
        n_pos = (r_pos == rmed_pkg::POS_MAX) ? r_pos : r_pos + PW'(1);
    end

    // Forwarding and status only ever use lengths that pass the limit,
    // so the low bits alone are enough for the field edges and the sum.
    always_comb begin
        len_ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (n_len[k][31:LW] != '0 || n_len[k][LW-1:0] > r_max) begin
                len_ok = 1'b0;
            end
        end
        edge1   = CW'(n_len[0][LW-1:0]);
        edge2   = edge1 + CW'(n_len[1][LW-1:0]);
        edge3   = edge2 + CW'(n_len[2][LW-1:0]);
        edge4   = edge3 + CW'(n_len[3][LW-1:0]);
        pos_ext = CW'(r_pos);
        offset  = pos_ext - CW'(rmed_pkg::POS_HEADER);
    end

    always_comb begin
        pay_hit = (r_pos >= rmed_pkg::POS_HEADER) && n_magic && len_ok && (offset < edge4);
        if (offset < edge1) begin
            pay_tag = rmed_pkg::TAG_SERVICE;
        end else if (offset < edge2) begin
            pay_tag = rmed_pkg::TAG_METHOD;
        end else if (offset < edge3) begin
            pay_tag = rmed_pkg::TAG_KEY;
        end else begin
            pay_tag = rmed_pkg::TAG_APPLICATION;
        end

        // Short header or bad magic take priority over length errors
        if (r_pos < rmed_pkg::POS_HDR_LAST || !n_magic) begin
            st = rmed_pkg::ST_MISSING;
        end else if (!len_ok || (edge4 + CW'(rmed_pkg::POS_HDR_LAST) > pos_ext)) begin
            st = rmed_pkg::ST_INVALID;
        end else begin
            st = rmed_pkg::ST_OK;
        end
    end

    always_comb begin
        pay_res        = '0;
        pay_res.kind   = rmed_pkg::KIND_PAYLOAD;
        pay_res.tag    = pay_tag;
        pay_res.data   = i_data_byte;
        pay_res.status = rmed_pkg::ST_OK;

        stat_res        = '0;
        stat_res.kind   = rmed_pkg::KIND_STATUS;
        stat_res.status = st;
        stat_res.last   = 1'b1;
        if (st == rmed_pkg::ST_OK) begin
            stat_res.timeout     = n_timeout;
            stat_res.service_len = n_len[0][LW-1:0];
            stat_res.method_len  = n_len[1][LW-1:0];
            stat_res.key_len     = n_len[2][LW-1:0];
            stat_res.app_len     = n_len[3][LW-1:0];
        end

        first_res = pay_hit ? pay_res : stat_res;
        push_one  = accept && (pay_hit || i_end_of_envelope);
        push_two  = accept && pay_hit && i_end_of_envelope;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= rmed_pkg::MAX_FIELD_RESET;
            r_pos     <= '0;
            r_magic   <= 1'b1;
            r_timeout <= '0;
            for (int k = 0; k < 4; k++) r_len[k] <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_end_of_envelope) begin
                    // Close the envelope: back to the reset header state
                    r_pos     <= '0;
                    r_magic   <= 1'b1;
                    r_timeout <= '0;
                    for (int k = 0; k < 4; k++) r_len[k] <= '0;
                end else begin
                    r_pos     <= n_pos;
                    r_magic   <= n_magic;
                    r_timeout <= n_timeout;
                    r_len     <= n_len;
                end
            end
        end
    end

    // Output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QW'(push_one) + QW'(push_two);
            r_rd_ptr <= r_rd_ptr + QW'(pop);
            r_count  <= r_count + NW'(push_one) + NW'(push_two) - NW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_one) begin
            r_queue[r_wr_ptr] <= first_res;
        end
        if (push_two) begin
            r_queue[r_wr_ptr + QW'(1)] <= stat_res;
        end
    end

    assign head                 = r_queue[r_rd_ptr];
    assign o_result_kind        = head.kind;
    assign o_field_tag          = head.tag;
    assign o_payload_byte       = head.data;
    assign o_status             = head.status;
    assign o_timeout_value      = head.timeout;
    assign o_service_length     = head.service_len;
    assign o_method_length      = head.method_len;
    assign o_key_length         = head.key_len;
    assign o_application_length = head.app_len;
    assign o_last_result        = head.last;

endmodule

// File: test/rpc_metadata_envelope_deframer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rpc_metadata_envelope_deframer_unit: byte driver, result monitor
// and a cycle-free predictor of the envelope parser. Depends on rmed_pkg and the unit RTL.
module rpc_metadata_envelope_deframer_unit_tb;

    localparam int          LW             = rmed_pkg::LEN_W;
    localparam int          PW             = rmed_pkg::POSITION_WIDTH;
    localparam logic [31:0] ENVELOPE_MAGIC = 32'h524D_3100;
    localparam int          MAX_PRINTED    = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       eoe;
    } t_envelope_byte;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [LW-1:0]       i_cfg_wr_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_data_byte = '0;
    logic                i_end_of_envelope = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_result_kind;
    logic [1:0]          o_field_tag;
    logic [7:0]          o_payload_byte;
    logic [1:0]          o_status;
    logic [63:0]         o_timeout_value;
    logic [LW-1:0]       o_service_length;
    logic [LW-1:0]       o_method_length;
    logic [LW-1:0]       o_key_length;
    logic [LW-1:0]       o_application_length;
    logic                o_last_result;

    rpc_metadata_envelope_deframer_unit DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_data_byte          (i_data_byte),
        .i_end_of_envelope    (i_end_of_envelope),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_result_kind        (o_result_kind),
        .o_field_tag          (o_field_tag),
        .o_payload_byte       (o_payload_byte),
        .o_status             (o_status),
        .o_timeout_value      (o_timeout_value),
        .o_service_length     (o_service_length),
        .o_method_length      (o_method_length),
        .o_key_length         (o_key_length),
        .o_application_length (o_application_length),
        .o_last_result        (o_last_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Predictor state, mirrors the parser between envelopes
    logic [LW-1:0]             max_len = rmed_pkg::MAX_FIELD_RESET;
    logic [PW-1:0]             env_pos = '0;
    logic                      magic_ok = 1'b1;
    logic [63:0]               timeout_acc = '0;
    logic [3:0][31:0]          len_acc = '0;
    logic                      hdr_done = 1'b0;

    t_envelope_byte    pending_bytes[$];
    rmed_pkg::t_result awaited_results[$];

    int  mismatches = 0;
    int  bytes_taken = 0;
    int  envelopes = 0;
    int  cfg_writes = 0;
    int  seen_payload = 0;
    int  seen_ok = 0;
    int  seen_missing = 0;
    int  seen_invalid = 0;
    bit  steady = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_cycle = 0;
    int  stall_mode = 0;
    t_envelope_byte    next_byte;
    rmed_pkg::t_result got;

    function automatic bit lengths_fit();
        bit fit;
        fit = 1'b1;
        for (int i = 0; i < 4; i++)
            if (len_acc[i] > 32'(max_len)) fit = 1'b0;
        return fit;
    endfunction

    task automatic clear_envelope();
        env_pos     = '0;
        magic_ok    = 1'b1;
        timeout_acc = '0;
        len_acc     = '0;
        hdr_done    = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic eoe);
        logic [PW-1:0]             pos;
        logic [1:0]                k;
        logic [34:0]               off;
        logic [34:0]               bound;
        logic [34:0]               sum;
        logic [34:0]               total;
        bit                        placed;
        rmed_pkg::t_result         r;
        pos = env_pos;
        if (pos < rmed_pkg::POS_TIMEOUT) begin
            if (b != ENVELOPE_MAGIC[31 - 8 * pos[1:0] -: 8]) magic_ok = 1'b0;
        end else if (pos < rmed_pkg::POS_LENGTHS) begin
            timeout_acc = {timeout_acc[55:0], b};
        end else if (pos < rmed_pkg::POS_HEADER) begin
            k = 2'((pos - rmed_pkg::POS_LENGTHS) >> 2);
            len_acc[k] = {len_acc[k][23:0], b};
            if (pos == rmed_pkg::POS_HDR_LAST) hdr_done = 1'b1;
        end else if (hdr_done && magic_ok && lengths_fit()) begin
            off    = 35'(pos - rmed_pkg::POS_HEADER);
            bound  = '0;
            placed = 1'b0;
            for (int t = 0; t < 4; t++) begin
                bound = bound + 35'(len_acc[t]);
                if (!placed && off < bound) begin
                    r        = '0;
                    r.kind   = rmed_pkg::KIND_PAYLOAD;
                    r.tag    = 2'(t);
                    r.data   = b;
                    r.status = rmed_pkg::ST_OK;
                    awaited_results.push_back(r);
                    placed   = 1'b1;
                end
            end
        end
        // hold the count once it saturates
        if (pos != rmed_pkg::POS_MAX) env_pos = pos + 1'b1;
        if (eoe) begin
            total    = 35'(pos) + 35'd1;
            r        = '0;
            r.kind   = rmed_pkg::KIND_STATUS;
            r.last   = 1'b1;
            if (total < 35'(rmed_pkg::POS_HEADER) || !magic_ok) begin
                r.status = rmed_pkg::ST_MISSING;
            end else begin
                sum = 35'(len_acc[0]) + 35'(len_acc[1]) + 35'(len_acc[2]) + 35'(len_acc[3]);
                if (!lengths_fit() || sum > total - 35'(rmed_pkg::POS_HEADER))
                    r.status = rmed_pkg::ST_INVALID;
                else
                    r.status = rmed_pkg::ST_OK;
            end
            if (r.status == rmed_pkg::ST_OK) begin
                r.timeout     = timeout_acc;
                r.service_len = len_acc[0][LW-1:0];
                r.method_len  = len_acc[1][LW-1:0];
                r.key_len     = len_acc[2][LW-1:0];
                r.app_len     = len_acc[3][LW-1:0];
            end
            awaited_results.push_back(r);
            clear_envelope();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch %s: got %0h want %0h", $time, what, seen, want);
        mismatches++;
    endtask

    task automatic check_result(input rmed_pkg::t_result r);
        rmed_pkg::t_result e;
        if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(r.kind), 64'(r.data));
        end else begin
            e = awaited_results.pop_front();
            if (r.kind != e.kind)               report_mismatch("kind", 64'(r.kind), 64'(e.kind));
            if (r.tag != e.tag)                 report_mismatch("tag", 64'(r.tag), 64'(e.tag));
            if (r.data != e.data)               report_mismatch("byte", 64'(r.data), 64'(e.data));
            if (r.status != e.status)
                report_mismatch("status", 64'(r.status), 64'(e.status));
            if (r.timeout != e.timeout)         report_mismatch("timeout", r.timeout, e.timeout);
            if (r.service_len != e.service_len)
                report_mismatch("service length", 64'(r.service_len), 64'(e.service_len));
            if (r.method_len != e.method_len)
                report_mismatch("method length", 64'(r.method_len), 64'(e.method_len));
            if (r.key_len != e.key_len)
                report_mismatch("key length", 64'(r.key_len), 64'(e.key_len));
            if (r.app_len != e.app_len)
                report_mismatch("application length", 64'(r.app_len), 64'(e.app_len));
            if (r.last != e.last)               report_mismatch("last", 64'(r.last), 64'(e.last));
            if (e.kind == rmed_pkg::KIND_PAYLOAD) seen_payload++;
            else if (e.status == rmed_pkg::ST_OK) seen_ok++;
            else if (e.status == rmed_pkg::ST_MISSING) seen_missing++;
            else seen_invalid++;
        end
    endtask

    // Byte driver: bursts of random length, random gaps, none while steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_data_byte, i_end_of_envelope);
                bytes_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0 && !steady) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_byte = pending_bytes.pop_front();
                    i_in_valid        <= 1'b1;
                    i_data_byte       <= next_byte.data;
                    i_end_of_envelope <= next_byte.eoe;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got             = '0;
            got.kind        = o_result_kind;
            got.tag         = o_field_tag;
            got.data        = o_payload_byte;
            got.status      = rmed_pkg::t_status'(o_status);
            got.timeout     = o_timeout_value;
            got.service_len = o_service_length;
            got.method_len  = o_method_length;
            got.key_len     = o_key_length;
            got.app_len     = o_application_length;
            got.last        = o_last_result;
            check_result(got);
        end
        stall_cycle++;
        if (stall_cycle % 200 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 30);
            2:       i_out_stall <= ($urandom_range(0, 99) < 75);
            default: i_out_stall <= (stall_cycle % 4 != 0);
        endcase
    end

    // Build one envelope: magic (optionally corrupted), timeout, lengths, body; cut > 0
    // truncates the whole envelope to that many bytes
    task automatic queue_envelope(input int bad_magic, input logic [63:0] tmo,
                                  input logic [3:0][31:0] lens, input int body,
                                  input int cut, output int n);
        logic [7:0]     bytes[$];
        logic [7:0]     mb;
        t_envelope_byte eb;
        for (int i = 0; i < 4; i++) begin
            mb = ENVELOPE_MAGIC[31 - 8 * i -: 8];
            if (i == bad_magic) mb = mb ^ 8'($urandom_range(1, 255));
            bytes.push_back(mb);
        end
        for (int i = 7; i >= 0; i--) bytes.push_back(tmo[8 * i +: 8]);
        for (int j = 0; j < 4; j++)
            for (int i = 3; i >= 0; i--) bytes.push_back(lens[j][8 * i +: 8]);
        for (int i = 0; i < body; i++) bytes.push_back(8'($urandom));
        if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
        n = bytes.size();
        for (int i = 0; i < n; i++) begin
            eb.data = bytes[i];
            eb.eoe  = (i == n - 1);
            pending_bytes.push_back(eb);
        end
        envelopes++;
    endtask

    // Wait for the sender to finish and every expected result, then let the queue settle
    task automatic drain();
        @(posedge i_clk);
        while (pending_bytes.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [LW-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        max_len = value;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input int quota);
        int               sent;
        int               n;
        int               pick;
        int               cap;
        int               sum;
        int               body;
        int               victim;
        logic [3:0][31:0] lens;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            cap  = (max_len > 6) ? 6 : int'(max_len);
            sum  = 0;
            for (int i = 0; i < 4; i++) begin
                lens[i] = $urandom_range(0, cap);
                if ($urandom_range(0, 6) == 0 && max_len <= 40) lens[i] = 32'(max_len);
                sum += lens[i];
            end
            body = sum + $urandom_range(0, 3);
            if (pick < 70) begin
                // well formed, now and then truncated
                if ($urandom_range(0, 4) == 0 && sum > 0) body = $urandom_range(0, sum - 1);
                queue_envelope(-1, {$urandom, $urandom}, lens, body, 0, n);
            end else if (pick < 80) begin
                queue_envelope($urandom_range(0, 3), {$urandom, $urandom}, lens, body, 0, n);
            end else if (pick < 90) begin
                queue_envelope(-1, {$urandom, $urandom}, lens, body, $urandom_range(1, 27), n);
            end else begin
                victim = $urandom_range(0, 3);
                lens[victim] = $urandom_range(0, 1) ? 32'(max_len) + 32'd1 : 32'($urandom);
                queue_envelope(-1, {$urandom, $urandom}, lens, $urandom_range(0, 6), 0, n);
            end
            sent += n;
        end
    endtask

    initial begin
        int               n;
        logic [LW-1:0]    phase_max [7];
        phase_max = '{17'd65536, 17'd0, 17'd1, 17'd5, 17'd40,
                      LW'($urandom_range(0, 65536)), 17'd65535};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // end mark on the very first byte, and a header one byte short
        queue_envelope(-1, 64'h0, '0, 0, 1, n);
        queue_envelope(-1, 64'h1122_3344_5566_7788, '0, 0, 27, n);
        // all lengths zero: a bare header, then two trailing bytes; timeout at both extremes
        queue_envelope(-1, 64'hFFFF_FFFF_FFFF_FFFF, '0, 0, 0, n);
        queue_envelope(-1, 64'h0, '0, 2, 0, n);
        // bad magic wins over an oversize length
        queue_envelope(3, 64'h5, {32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF}, 2, 0, n);
        // one byte per field plus trailing bytes to drop
        queue_envelope(-1, 64'h7, {32'd1, 32'd1, 32'd1, 32'd1}, 6, 0, n);
        // final byte is itself payload
        queue_envelope(-1, 64'h8, {32'd2, 32'd0, 32'd0, 32'd0}, 2, 0, n);
        // length exactly at the limit, data truncated: forwarded bytes stay forwarded
        queue_envelope(-1, 64'h9, {32'd0, 32'd0, 32'd0, 32'd65536}, 3, 0, n);
        // one past the limit: nothing forwarded
        queue_envelope(-1, 64'hA, {32'd0, 32'd65537, 32'd0, 32'd0}, 3, 0, n);
        queue_envelope(-1, 64'hB, {32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0}, 1, 0, n);
        drain();

        foreach (phase_max[p]) begin
            write_max_length(phase_max[p]);
            random_phase(120);
            drain();
        end

        // a longer envelope with the sender never idle
        write_max_length(17'd65536);
        steady = 1'b1;
        queue_envelope(-1, {$urandom, $urandom}, {32'd2, 32'd0, 32'd0, 32'd1}, 40, 0, n);
        drain();
        steady = 1'b0;
        // the parser must be clean again afterwards
        queue_envelope(-1, 64'hC, {32'd1, 32'd1, 32'd0, 32'd1}, 3, 0, n);
        drain();

        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 64'(awaited_results.size()), 64'd0);
        $display("Covered %0d envelopes in %0d bytes, reset limit plus %0d limit writes.",
                 envelopes, bytes_taken, cfg_writes);
        $display("Results: %0d tagged bytes, %0d ok, %0d missing, %0d invalid; %0d mismatches.",
                 seen_payload, seen_ok, seen_missing, seen_invalid, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
